FILE: src/lsmc_pkg.sv
// ----------------------------------------------------------------------------
// lsmc_pkg
// Shared constants, types and lattice helpers for the swap Monte Carlo step.
// ----------------------------------------------------------------------------
package lsmc_pkg;

   // Lattice geometry; SIDE is a power of two so coordinates unpack by shifts
   localparam int SIDE   = 16;
   localparam int CW     = $clog2(SIDE);
   localparam int NSITES = SIDE * SIDE * SIDE;
   localparam int AW     = $clog2(NSITES);

   // Field widths
   localparam int SITE_W = 12;
   localparam int SPEC_W = 2;
   localparam int DRAW_W = 24;
   localparam int BETA_W = 16;
   localparam int DE_W   = 10;
   localparam int CNT_W  = 3;
   localparam int PROD_W = BETA_W + DE_W - 1;

   localparam logic [BETA_W-1:0] BETA_RESET = 16'd1536;

   // Target occupancy per species
   localparam logic [3:0] TARGET_ONE = 4'd3;
   localparam logic [3:0] TARGET_TWO = 4'd5;
   localparam logic [2:0] LAST_DIR   = 3'd6;

   // Item opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_SWAP  = 2'd2;

   // Species codes
   localparam logic [SPEC_W-1:0] SP_VACANT = 2'd0;
   localparam logic [SPEC_W-1:0] SP_ONE    = 2'd1;
   localparam logic [SPEC_W-1:0] SP_BAD    = 2'd3;

   typedef logic [CW-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } xyz_type;

   typedef enum logic [1:0] {RD_NONE, RD_A, RD_B, RD_SCAN} rd_sel_type;
   typedef enum logic [2:0] {WR_NONE, WR_CLR, WR_ITEM, WR_A_SWAP, WR_B_SWAP} wr_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       latch;
      rd_sel_type rd_sel;
      logic       cap_a;
      logic       cap_b;
      logic       scan_pass;
      logic       scan_hood;
      logic [2:0] scan_ctr;
      logic [2:0] scan_nb;
      logic       mul;
      logic       dec;
      wr_sel_type wr_sel;
      logic       resp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] op;
      logic       wr_ok;
      logic       swap_ok;
      logic       keep;
      logic       clear_last;
      logic       rsp_free;
   } sts_type;

   function automatic coord_type inc_c(coord_type c);
      return (int'(c) == SIDE - 1) ? '0 : c + coord_type'(1);
   endfunction

   function automatic coord_type dec_c(coord_type c);
      return (c == '0) ? coord_type'(SIDE - 1) : c - coord_type'(1);
   endfunction

   function automatic xyz_type to_xyz(logic [AW-1:0] s);
      xyz_type r;
      r.x = coord_type'(s >> (2 * CW));
      r.y = coord_type'(s >> CW);
      r.z = coord_type'(s);
      return r;
   endfunction

   function automatic logic [AW-1:0] to_addr(xyz_type p);
      return {p.x, p.y, p.z};
   endfunction

   // Direction 0 is the site itself, 1..6 are +x -x +y -y +z -z
   function automatic xyz_type step(xyz_type p, logic [2:0] dir);
      xyz_type r;
      r = p;
      case (dir)
         3'd1: r.x = inc_c(p.x);
         3'd2: r.x = dec_c(p.x);
         3'd3: r.y = inc_c(p.y);
         3'd4: r.y = dec_c(p.y);
         3'd5: r.z = inc_c(p.z);
         3'd6: r.z = dec_c(p.z);
         default: r = p;
      endcase
      return r;
   endfunction

endpackage

FILE: src/lsmc_ram.sv
// ----------------------------------------------------------------------------
// lsmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsmc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lsmc_ctrl.sv
// ----------------------------------------------------------------------------
// lsmc_ctrl
// Sequencer: clearing pass, item dispatch, neighborhood scan and writeback.
// ----------------------------------------------------------------------------
module lsmc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_opcode,
   input  lsmc_pkg::sts_type sts,
   output lsmc_pkg::cmd_type cmd
);
   import lsmc_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_WR    = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_CAPR  = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_CHK   = 4'd6;
   localparam logic [3:0] S_EQ    = 4'd7;
   localparam logic [3:0] S_SCAN  = 4'd8;
   localparam logic [3:0] S_DRAIN = 4'd9;
   localparam logic [3:0] S_MUL   = 4'd10;
   localparam logic [3:0] S_DEC   = 4'd11;
   localparam logic [3:0] S_WRA   = 4'd12;
   localparam logic [3:0] S_WRB   = 4'd13;
   localparam logic [3:0] S_RESP  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       pass_ff, pass_in;
   logic       hood_ff, hood_in;
   logic [2:0] ctr_ff, ctr_in;
   logic [2:0] nb_ff, nb_in;
   logic       scan_last;

   assign req_ready = (state_ff == S_IDLE);
   assign scan_last = pass_ff && hood_ff && (ctr_ff == LAST_DIR) && (nb_ff == LAST_DIR);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      hood_in  = hood_ff;
      ctr_in   = ctr_ff;
      nb_in    = nb_ff;
      cmd           = '0;
      cmd.rd_sel    = RD_NONE;
      cmd.wr_sel    = WR_NONE;
      cmd.scan_pass = pass_ff;
      cmd.scan_hood = hood_ff;
      cmd.scan_ctr  = ctr_ff;
      cmd.scan_nb   = nb_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_sel = WR_CLR;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (req_opcode) inside
                  OP_WRITE:        state_in = S_WR;
                  OP_READ, OP_SWAP: state_in = S_RDA;
                  default:         state_in = S_RESP;
               endcase
            end
         end
         S_WR: begin
            if (sts.wr_ok) cmd.wr_sel = WR_ITEM;
            state_in = S_RESP;
         end
         S_RDA: begin
            cmd.rd_sel = RD_A;
            state_in = (sts.op == OP_READ) ? S_CAPR : S_RDB;
         end
         S_CAPR: begin
            cmd.cap_a = 1'b1;
            state_in = S_RESP;
         end
         S_RDB: begin
            cmd.cap_a  = 1'b1;
            cmd.rd_sel = RD_B;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.cap_b = 1'b1;
            state_in = S_EQ;
         end
         S_EQ: begin
            pass_in = 1'b0;
            hood_in = 1'b0;
            ctr_in  = '0;
            nb_in   = '0;
            state_in = sts.swap_ok ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            // Walk neighbor, center, hood, pass
            cmd.rd_sel = RD_SCAN;
            if (scan_last) begin
               state_in = S_DRAIN;
            end else if (nb_ff != LAST_DIR) begin
               nb_in = nb_ff + 3'd1;
            end else begin
               nb_in = '0;
               if (ctr_ff != LAST_DIR) begin
                  ctr_in = ctr_ff + 3'd1;
               end else begin
                  ctr_in  = '0;
                  hood_in = !hood_ff;
                  if (hood_ff) pass_in = 1'b1;
               end
            end
         end
         S_DRAIN: state_in = S_MUL;
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.dec = 1'b1;
            state_in = S_WRA;
         end
         S_WRA: begin
            if (sts.keep) begin
               cmd.wr_sel = WR_A_SWAP;
               state_in = S_WRB;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRB: begin
            cmd.wr_sel = WR_B_SWAP;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pass_ff  <= 1'b0;
         hood_ff  <= 1'b0;
         ctr_ff   <= '0;
         nb_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         hood_ff  <= hood_in;
         ctr_ff   <= ctr_in;
         nb_ff    <= nb_in;
      end
   end

   // Checks
   a_wrb_after_wra: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRB |-> $past(state_ff) == S_WRA)
      else $error("second swap write without first");
   a_scan_enter: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EQ && sts.swap_ok |=> state_ff == S_SCAN && nb_ff == '0 && !pass_ff)
      else $error("scan did not start at origin");
   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |-> $past(state_ff) == S_SCAN)
      else $error("drain without scan");

endmodule

FILE: src/lsmc_dpath.sv
// ----------------------------------------------------------------------------
// lsmc_dpath
// Item registers, site store, neighborhood energy accumulator, Metropolis
// test and result register.
// ----------------------------------------------------------------------------
module lsmc_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  lsmc_pkg::cmd_type             cmd,
   output lsmc_pkg::sts_type             sts,
   input  logic [1:0]                   req_opcode,
   input  logic [lsmc_pkg::SITE_W-1:0]  req_site_a,
   input  logic [lsmc_pkg::SITE_W-1:0]  req_site_b,
   input  logic [lsmc_pkg::SPEC_W-1:0]  req_species_in,
   input  logic [lsmc_pkg::DRAW_W-1:0]  req_log_draw,
   input  logic                         csr_wr_en,
   input  logic [lsmc_pkg::BETA_W-1:0]  csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_accepted,
   output logic signed [lsmc_pkg::DE_W-1:0] rsp_energy_change,
   output logic [lsmc_pkg::SPEC_W-1:0]  rsp_species_out
);
   import lsmc_pkg::*;

   // Item and config registers
   logic [1:0]        op_ff;
   logic [SITE_W-1:0] a_ff, b_ff;
   logic [SPEC_W-1:0] spin_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic [BETA_W-1:0] beta_ff;
   logic [SPEC_W-1:0] sa_ff, sb_ff;
   logic [SPEC_W-1:0] rd_data;
   logic              a_ok, b_ok;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_opcode;
         a_ff    <= req_site_a;
         b_ff    <= req_site_b;
         spin_ff <= req_species_in;
         draw_ff <= req_log_draw;
      end
      if (cmd.cap_a) sa_ff <= rd_data;
      if (cmd.cap_b) sb_ff <= rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) beta_ff <= BETA_RESET;
      else if (csr_wr_en) beta_ff <= csr_wr_data;
   end

   assign a_ok = int'(a_ff) < NSITES;
   assign b_ok = int'(b_ff) < NSITES;

   // Scan address: hood origin, then center, then neighbor
   xyz_type           base_p, cen_p, nbr_p;
   logic [AW-1:0]     scan_addr, rd_addr, wr_addr;
   logic [SPEC_W-1:0] wr_data;
   logic              wr_en;
   logic [AW-1:0]     clr_ff;

   always_comb begin
      base_p    = to_xyz(cmd.scan_hood ? AW'(b_ff) : AW'(a_ff));
      cen_p     = step(base_p, cmd.scan_ctr);
      nbr_p     = step(cen_p, cmd.scan_nb);
      scan_addr = to_addr(nbr_p);
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_A:    rd_addr = AW'(a_ff);
         RD_B:    rd_addr = AW'(b_ff);
         default: rd_addr = scan_addr;
      endcase
   end

   // Store write port
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = AW'(a_ff);
      wr_data = spin_ff;
      case (cmd.wr_sel)
         WR_CLR: begin
            wr_addr = clr_ff;
            wr_data = SP_VACANT;
         end
         WR_ITEM:   wr_data = spin_ff;
         WR_A_SWAP: wr_data = sb_ff;
         WR_B_SWAP: begin
            wr_addr = AW'(b_ff);
            wr_data = sa_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.wr_sel == WR_CLR) clr_ff <= clr_ff + AW'(1);
   end

   lsmc_ram #(.WIDTH(SPEC_W), .DEPTH(NSITES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Tag that trails each scan read by a register, lining up with the read data
   logic scan_vld_ff, tag_pass_ff, tag_first_ff, tag_last_ff, tag_isa_ff, tag_isb_ff;

   always_ff @(posedge clock) begin
      if (reset) scan_vld_ff <= 1'b0;
      else scan_vld_ff <= (cmd.rd_sel == RD_SCAN);
      tag_pass_ff  <= cmd.scan_pass;
      tag_first_ff <= (cmd.scan_nb == '0);
      tag_last_ff  <= (cmd.scan_nb == LAST_DIR);
      tag_isa_ff   <= (scan_addr == AW'(a_ff));
      tag_isb_ff   <= (scan_addr == AW'(b_ff));
   end

   // Site energy and running dE; the after pass sees the two sites exchanged
   logic [SPEC_W-1:0]         sp_eff, cen_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_next;
   logic signed [3:0]         dev;
   logic [4:0]                e_site;
   logic signed [DE_W-1:0]    acc_ff;

   always_comb begin
      if (tag_pass_ff && tag_isa_ff)      sp_eff = sb_ff;
      else if (tag_pass_ff && tag_isb_ff) sp_eff = sa_ff;
      else                                sp_eff = rd_data;
      cnt_next = cnt_ff + CNT_W'(sp_eff != SP_VACANT);
      dev      = $signed({1'b0, cnt_next}) -
                 $signed((cen_ff == SP_ONE) ? TARGET_ONE : TARGET_TWO);
      e_site   = (cen_ff == SP_VACANT) ? 5'd0 : 5'(dev * dev);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         acc_ff <= '0;
      end else if (scan_vld_ff) begin
         if (tag_first_ff) begin
            cen_ff <= sp_eff;
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_next;
            if (tag_last_ff) begin
               acc_ff <= tag_pass_ff ? acc_ff + DE_W'(e_site) : acc_ff - DE_W'(e_site);
            end
         end
      end
   end

   // Metropolis test: keep when dE <= 0 or beta * dE * 256 < draw
   logic [PROD_W-1:0] prod_ff;
   logic              keep_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= PROD_W'(beta_ff * acc_ff[DE_W-2:0]);
      if (cmd.latch) begin
         keep_ff <= 1'b0;
      end else if (cmd.dec) begin
         keep_ff <= (acc_ff <= 0) ||
                    ({prod_ff, 8'd0} < (PROD_W + 8)'(draw_ff));
      end
   end

   assign sts.op         = op_ff;
   assign sts.wr_ok      = a_ok && (spin_ff != SP_BAD);
   assign sts.swap_ok    = a_ok && b_ok && (sa_ff != sb_ff);
   assign sts.keep       = keep_ff;
   assign sts.clear_last = (int'(clr_ff) == NSITES - 1);
   assign sts.rsp_free   = !rsp_valid || rsp_ready;

   // Result register
   logic                   rsp_valid_ff;
   logic                   acc_out_ff;
   logic signed [DE_W-1:0] de_out_ff;
   logic [SPEC_W-1:0]      spo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.resp_load) begin
         acc_out_ff <= keep_ff;
         de_out_ff  <= acc_ff;
         spo_ff     <= (op_ff == OP_READ && a_ok) ? sa_ff : SP_VACANT;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_out_ff;
   assign rsp_energy_change = de_out_ff;
   assign rsp_species_out   = spo_ff;

   // Checks
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |=> (acc_ff <= 350 && acc_ff >= -350))
      else $error("energy change out of range");
   a_read_beat_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_species_out != SP_VACANT |-> !rsp_accepted && rsp_energy_change == 0)
      else $error("read beat carries swap fields");
   a_no_load_mid_scan: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |-> !cmd.resp_load && cmd.wr_sel == WR_NONE)
      else $error("result or write during scan");

endmodule

FILE: src/lattice_swap_monte_carlo_step_top.sv
// ----------------------------------------------------------------------------
// lattice_swap_monte_carlo_step_top
// Metropolis swap step on a periodic cubic lattice glass.
// ----------------------------------------------------------------------------
// After reset the block sweeps the site store to vacant, one site per cycle,
// and accepts no item until done. Write items, read items, other non-swap
// items and swaps that are skipped (equal species or bad index) end with
// result handoff after their store accesses. A swap with differing species
// visits the single read port of the site store once for each of 196
// reads (two passes, before and after exchange, of both neighborhoods of 7
// sites with 7 reads each), then a drain state for the last read, the dE
// multiply, the acceptance compare and one write per site when kept.
// One item is in work at a time; a finished result waits in an output register.
module lattice_swap_monte_carlo_step_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [lsmc_pkg::SITE_W-1:0]         req_site_a,
   input  logic [lsmc_pkg::SITE_W-1:0]         req_site_b,
   input  logic [lsmc_pkg::SPEC_W-1:0]         req_species_in,
   input  logic [lsmc_pkg::DRAW_W-1:0]         req_log_draw,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic signed [lsmc_pkg::DE_W-1:0]    rsp_energy_change,
   output logic [lsmc_pkg::SPEC_W-1:0]         rsp_species_out,
   input  logic                                csr_wr_en,
   input  logic [lsmc_pkg::BETA_W-1:0]         csr_wr_data
);
   import lsmc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lsmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   lsmc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_site_a        (req_site_a),
      .req_site_b        (req_site_b),
      .req_species_in    (req_species_in),
      .req_log_draw      (req_log_draw),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_energy_change (rsp_energy_change),
      .rsp_species_out   (rsp_species_out)
   );

endmodule

FILE: tb/lattice_swap_monte_carlo_step_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lattice_swap_monte_carlo_step_top_tb
// Self-checking bench for the lattice glass swap step: a directed table of
// writes, reads and swaps, then random traffic on a small dense cluster of
// sites, all scored against an in-bench lattice energy predictor.
// ----------------------------------------------------------------------------
module lattice_swap_monte_carlo_step_top_tb;
   import lsmc_pkg::*;

   typedef struct packed {
      logic [1:0]        op;
      logic [SITE_W-1:0] a;
      logic [SITE_W-1:0] b;
      logic [SPEC_W-1:0] sp;
      logic [DRAW_W-1:0] draw;
   } req_beat_type;

   typedef struct packed {
      logic              acc;
      logic [DE_W-1:0]   de;
      logic [SPEC_W-1:0] spo;
   } rsp_beat_type;

   typedef struct {
      req_beat_type req;
      logic         chk;
      rsp_beat_type want;
   } dir_row_type;

   localparam logic [1:0] OP_NOP = 2'd3;
   localparam logic [SPEC_W-1:0] SP_TWO = 2'd2;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic [SITE_W-1:0] req_site_a, req_site_b;
   logic [SPEC_W-1:0] req_species_in;
   logic [DRAW_W-1:0] req_log_draw;
   logic rsp_valid, rsp_ready, rsp_accepted;
   logic signed [DE_W-1:0] rsp_energy_change;
   logic [SPEC_W-1:0] rsp_species_out;
   logic csr_wr_en;
   logic [BETA_W-1:0] csr_wr_data;

   lattice_swap_monte_carlo_step_top uut (.*);

   // Predictor state
   logic [SPEC_W-1:0] lattice [NSITES];
   logic [BETA_W-1:0] beta;
   rsp_beat_type      pending_rsp [$];
   int                errors;
   int                tx_idle_pct, rx_idle_pct;
   logic              rx_hold;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int nbr_of(int s, int dir);
      int x, y, z;
      x = s / (SIDE * SIDE);
      y = (s / SIDE) % SIDE;
      z = s % SIDE;
      case (dir)
         0: x = (x + 1) % SIDE;
         1: x = (x + SIDE - 1) % SIDE;
         2: y = (y + 1) % SIDE;
         3: y = (y + SIDE - 1) % SIDE;
         4: z = (z + 1) % SIDE;
         default: z = (z + SIDE - 1) % SIDE;
      endcase
      return x * SIDE * SIDE + y * SIDE + z;
   endfunction

   function automatic int site_cost(int s);
      int n, d;
      n = 0;
      if (lattice[s] == SP_VACANT) return 0;
      for (int k = 0; k < 6; k++)
         if (lattice[nbr_of(s, k)] != SP_VACANT) n++;
      d = n - ((lattice[s] == SP_ONE) ? 3 : 5);
      return d * d;
   endfunction

   function automatic int hood_cost(int s);
      int e;
      e = site_cost(s);
      for (int k = 0; k < 6; k++) e += site_cost(nbr_of(s, k));
      return e;
   endfunction

   // Applies one beat to the lattice copy and returns its result
   function automatic rsp_beat_type predict_step(req_beat_type r);
      rsp_beat_type o;
      logic [SPEC_W-1:0] t;
      int e1, de;
      longint prod;
      o = '0;
      case (r.op)
         OP_WRITE: if (r.a < NSITES && r.sp != SP_BAD) lattice[r.a] = r.sp;
         OP_READ:  if (r.a < NSITES) o.spo = lattice[r.a];
         OP_SWAP: begin
            if (r.a < NSITES && r.b < NSITES && lattice[r.a] != lattice[r.b]) begin
               e1 = hood_cost(r.a) + hood_cost(r.b);
               t = lattice[r.a]; lattice[r.a] = lattice[r.b]; lattice[r.b] = t;
               de = hood_cost(r.a) + hood_cost(r.b) - e1;
               prod = longint'(beta) * de * 256;
               o.de = DE_W'(de);
               if (de <= 0 || prod < longint'(r.draw)) o.acc = 1'b1;
               else begin
                  t = lattice[r.a]; lattice[r.a] = lattice[r.b]; lattice[r.b] = t;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Offer one beat, honoring the sender idle rate; valid stays up on return
   task automatic send_beat(req_beat_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.op;
      req_site_a     <= r.a;
      req_site_b     <= r.b;
      req_species_in <= r.sp;
      req_log_draw   <= r.draw;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_step(r));
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_beta(logic [BETA_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      beta = v;
   endtask

   // Random site near the dense cluster at the origin corner (wraps around)
   function automatic logic [SITE_W-1:0] near_site();
      int x, y, z;
      x = ($urandom_range(3) + SIDE - 1) % SIDE;
      y = ($urandom_range(3) + SIDE - 1) % SIDE;
      z = ($urandom_range(3) + SIDE - 1) % SIDE;
      return SITE_W'(x * SIDE * SIDE + y * SIDE + z);
   endfunction

   function automatic req_beat_type rand_beat();
      req_beat_type r;
      int pick;
      r.a = near_site();
      r.b = near_site();
      r.sp = SPEC_W'($urandom_range(2));
      r.draw = DRAW_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) r.op = OP_WRITE;
      else if (pick < 45) r.op = OP_READ;
      else if (pick < 95) r.op = OP_SWAP;
      else begin
         r.op = 2'($urandom);
         r.a  = SITE_W'($urandom);
         r.b  = SITE_W'($urandom);
         r.sp = SPEC_W'($urandom);
      end
      return r;
   endfunction

   // Result checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat acc=%0b de=%0d sp=%0d", $time,
                     rsp_accepted, rsp_energy_change, rsp_species_out);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_accepted !== want.acc) begin
               $display("%0t: accepted exp %0b got %0b", $time, want.acc, rsp_accepted);
               errors++;
            end
            if (rsp_energy_change !== want.de) begin
               $display("%0t: energy_change exp %0d got %0d", $time,
                        $signed(want.de), rsp_energy_change);
               errors++;
            end
            if (rsp_species_out !== want.spo) begin
               $display("%0t: species_out exp %0d got %0d", $time, want.spo,
                        rsp_species_out);
               errors++;
            end
         end
      end
   end

   // Receiver ready: random idling plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (rx_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   initial begin
      dir_row_type  dir_tab [$];
      dir_row_type  row;
      rsp_beat_type got;
      errors = 0;
      tx_idle_pct = 26;
      rx_idle_pct = 65;
      rx_hold = 1'b0;
      beta = BETA_RESET;
      foreach (lattice[i]) lattice[i] = SP_VACANT;
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = OP_WRITE; req_site_a = '0; req_site_b = '0;
      req_species_in = '0; req_log_draw = '0;
      csr_wr_en = 1'b0; csr_wr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table: {op, a, b, species, draw}, check flag, expected
      dir_tab = '{
         '{'{OP_READ,  12'd0,    12'd0,    SP_VACANT, 24'd0}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_READ,  12'hFFF,  12'd0,    SP_VACANT, 24'd0}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_WRITE, 12'd0,    12'd0,    SP_ONE,    24'd0}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_READ,  12'd0,    12'd0,    SP_VACANT, 24'd0}, 1'b1, '{1'b0, 10'd0, SP_ONE}},
         '{'{OP_WRITE, 12'hFFF,  12'd0,    SP_TWO,    24'd0}, 1'b0, '0},
         '{'{OP_READ,  12'hFFF,  12'd0,    SP_VACANT, 24'd0}, 1'b1, '{1'b0, 10'd0, SP_TWO}},
         '{'{OP_WRITE, 12'd1,    12'd0,    SP_BAD,    24'd0}, 1'b0, '0},
         '{'{OP_READ,  12'd1,    12'd0,    SP_VACANT, 24'd0}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_SWAP,  12'd0,    12'd0,    SP_VACANT, 24'hFFFFFF}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_SWAP,  12'd2,    12'd3,    SP_VACANT, 24'hFFFFFF}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_NOP,   12'hFFF,  12'hFFF,  SP_BAD,    24'hFFFFFF}, 1'b1, '{1'b0, 10'd0, SP_VACANT}},
         '{'{OP_WRITE, 12'd1,    12'd0,    SP_TWO,    24'd0}, 1'b0, '0},
         '{'{OP_WRITE, 12'd16,   12'd0,    SP_ONE,    24'd0}, 1'b0, '0},
         '{'{OP_WRITE, 12'd256,  12'd0,    SP_ONE,    24'd0}, 1'b0, '0},
         '{'{OP_SWAP,  12'd0,    12'd1,    SP_VACANT, 24'd0}, 1'b0, '0},
         '{'{OP_SWAP,  12'd0,    12'd2,    SP_VACANT, 24'd0}, 1'b0, '0},
         '{'{OP_SWAP,  12'd0,    12'd2,    SP_VACANT, 24'hFFFFFF}, 1'b0, '0},
         '{'{OP_SWAP,  12'hFFF,  12'd17,   SP_VACANT, 24'h000100}, 1'b0, '0},
         '{'{OP_SWAP,  12'd1,    12'd272,  SP_VACANT, 24'd5}, 1'b0, '0},
         '{'{OP_READ,  12'd1,    12'd0,    SP_VACANT, 24'd0}, 1'b0, '0}
      };
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         send_beat(row.req);
         if (row.chk) begin
            got = pending_rsp[pending_rsp.size() - 1];
            if (got !== row.want) begin
               $display("%0t: row %0d predictor exp %h got %h", $time, i, row.want, got);
               errors++;
            end
         end
      end
      drain_wait();

      // Random phases over several beta settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_beta(16'd0);
            1: write_beta(16'hFFFF);
            2: write_beta(16'd1);
            3: write_beta(16'h0100);
            default: write_beta(BETA_W'($urandom));
         endcase
         tx_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 65 : 0;
         rx_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 26 : 0;
         if (ph == 3) begin
            // hold the receiver off while the sender keeps offering
            fork
               begin
                  rx_hold = 1'b1;
                  repeat (600) @(posedge clock);
                  rx_hold = 1'b0;
               end
               begin
                  for (int k = 0; k < 6; k++) send_beat(rand_beat());
                  req_valid <= 1'b0;
               end
            join
         end
         for (int k = 0; k < 95; k++) begin
            send_beat(rand_beat());
            if (k == 50) drain_wait();
         end
         drain_wait();
      end

      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
